// ----- sv/rrts_pkg.sv -----
package rrts_pkg;

    localparam int MAX_THREADS = 16;
    localparam int SLOT_W      = $clog2(MAX_THREADS);
    localparam int CNT_W       = 5;
    localparam int TICK_W      = 17;

    localparam logic [CNT_W-1:0] NO_SLOT = 5'd31;
    localparam logic [15:0]      TS_RESET = 16'd9000;

    // event kinds
    localparam logic [2:0] K_CREATE   = 3'd0;
    localparam logic [2:0] K_START    = 3'd1;
    localparam logic [2:0] K_WAIT     = 3'd2;
    localparam logic [2:0] K_STOP     = 3'd3;
    localparam logic [2:0] K_DESTROY  = 3'd4;
    localparam logic [2:0] K_TICK     = 3'd5;
    localparam logic [2:0] K_QUERY    = 3'd6;
    localparam logic [2:0] K_SHUTDOWN = 3'd7;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ACTIVE_A = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_MAIN     = 3'd4;
    localparam logic [2:0] ST_CURRENT  = 3'd5;
    localparam logic [2:0] ST_NOTSTOP  = 3'd6;

    // thread states
    localparam logic [2:0] TS_CREATED = 3'd0;
    localparam logic [2:0] TS_ACTIVE  = 3'd1;
    localparam logic [2:0] TS_WAITING = 3'd2;
    localparam logic [2:0] TS_STOPPED = 3'd3;

    // query selectors
    localparam logic [2:0] Q_ID    = 3'd0;
    localparam logic [2:0] Q_STATE = 3'd1;
    localparam logic [2:0] Q_TICKS = 3'd2;
    localparam logic [2:0] Q_IP    = 3'd3;
    localparam logic [2:0] Q_START = 3'd4;
    localparam logic [2:0] Q_END   = 3'd5;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] thr_id;
        logic [31:0] start_addr;
        logic [31:0] end_addr;
        logic [31:0] cur_ip;
        logic [2:0]  query_field;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        switched;
        logic [31:0] new_ip;
        logic [31:0] new_start;
        logic [31:0] new_end;
        logic [4:0]  current_slot;
        logic [4:0]  thread_count;
        logic [31:0] query_value;
    } t_result;

    typedef struct packed {
        logic [15:0]       id;
        logic [2:0]        state;
        logic [31:0]       ip;
        logic [31:0]       start_a;
        logic [31:0]       end_a;
        logic [TICK_W-1:0] ticks;
    } t_row;

endpackage

// ----- sv/rrts_mem.sv -----
module rrts_mem (
    input  logic                       i_clk,
    input  logic                       i_re,
    input  logic [rrts_pkg::SLOT_W-1:0] i_raddr,
    output rrts_pkg::t_row             o_rdata,
    input  logic                       i_we,
    input  logic [rrts_pkg::SLOT_W-1:0] i_waddr,
    input  rrts_pkg::t_row             i_wdata
);

    rrts_pkg::t_row mem [rrts_pkg::MAX_THREADS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

// ----- sv/round_robin_thread_scheduler.sv -----
// Channel   Direction  Handshake                 Word
// event     in         start & !busy             i_item (t_item)
// result    out        o_done, one-cycle strobe  o_result (t_result)
// config    in         i_cfg_we                  i_cfg_data (time slice)
//
// One event at a time. Create, shutdown and a tick with nothing running go
// straight to the result, a plain tick reads the running row; the rest walk
// the table through one read port, slot by slot for an id search or scan, with
// a read and a write per slot for the destroy compaction.
// Synchronous active-low reset clears count, run id; sets NO_SLOT, TS_RESET.
// The result is held off by nobody: o_done pulses once per event.
module round_robin_thread_scheduler (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  rrts_pkg::t_item   i_item,
    output logic              o_done,
    output rrts_pkg::t_result o_result,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data
);

    localparam int SW = rrts_pkg::SLOT_W;
    localparam int CW = rrts_pkg::CNT_W;

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_FIND    = 4'd1;
    localparam logic [3:0] S_DISP    = 4'd2;
    localparam logic [3:0] S_TICK    = 4'd3;
    localparam logic [3:0] S_CMP_RD  = 4'd4;
    localparam logic [3:0] S_CMP_WR  = 4'd5;
    localparam logic [3:0] S_NXT     = 4'd6;
    localparam logic [3:0] S_ACT_RD  = 4'd7;
    localparam logic [3:0] S_ACT_WR1 = 4'd8;
    localparam logic [3:0] S_ACT_WR2 = 4'd9;
    localparam logic [3:0] S_STOP_RD = 4'd10;
    localparam logic [3:0] S_STOP_WR = 4'd11;
    localparam logic [3:0] S_FIN     = 4'd12;

    logic [3:0]     r_state, n_state;
    rrts_pkg::t_item r_item, n_item;
    logic [15:0]    r_tid, n_tid;
    logic [15:0]    r_ts;
    logic [CW-1:0]  r_run, n_run;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [15:0]    r_run_id, n_run_id;
    logic [SW-1:0]  r_slot, n_slot;     // slot found by id
    logic [SW-1:0]  r_tslot, n_tslot;   // slot to activate
    logic [SW-1:0]  r_ptr, n_ptr;
    logic [SW-1:0]  r_pslot, n_pslot;   // slot of the pending read
    logic [CW-1:0]  r_k, n_k;
    logic           r_pend, n_pend;
    logic           r_stopm, n_stopm;   // scan belongs to a stop
    rrts_pkg::t_row r_row, n_row;
    rrts_pkg::t_result r_res, n_res;

    logic           mem_re, mem_we;
    logic [SW-1:0]  mem_raddr, mem_waddr;
    rrts_pkg::t_row mem_rdata, mem_wdata;

    logic           run_ok;
    logic [SW-1:0]  run_s;
    logic           is_run;
    logic           issue;
    logic [CW-1:0]  base, first;
    logic [CW-1:0]  ptr_nx;
    logic [CW-1:0]  wrap_nx;

    rrts_mem u_mem (
        .i_clk   (i_clk),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata)
    );

    assign run_ok  = r_run < r_cnt;
    assign run_s   = r_run[SW-1:0];
    assign is_run  = run_ok && ({1'b0, r_slot} == r_run);
    assign issue   = r_k < r_cnt;
    // round-robin start point: after the running slot, else slot 0
    assign base    = run_ok ? r_run : r_cnt - 5'd1;
    assign first   = (base + 5'd1 == r_cnt) ? 5'd0 : base + 5'd1;
    assign ptr_nx  = {1'b0, r_ptr} + 5'd1;
    assign wrap_nx = (ptr_nx == r_cnt) ? 5'd0 : ptr_nx;

    always_comb begin
        n_state  = r_state;
        n_item   = r_item;
        n_tid    = r_tid;
        n_run    = r_run;
        n_cnt    = r_cnt;
        n_run_id = r_run_id;
        n_slot   = r_slot;
        n_tslot  = r_tslot;
        n_ptr    = r_ptr;
        n_pslot  = r_pslot;
        n_k      = r_k;
        n_pend   = r_pend;
        n_stopm  = r_stopm;
        n_row    = r_row;
        n_res    = r_res;
        mem_re    = 1'b0;
        mem_raddr = r_ptr;
        mem_we    = 1'b0;
        mem_waddr = r_slot;
        mem_wdata = r_row;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item  = i_item;
                    n_tid   = i_item.thr_id;
                    n_res   = '0;
                    n_k     = '0;
                    n_pend  = 1'b0;
                    n_stopm = 1'b0;
                    case (i_item.kind)
                        rrts_pkg::K_CREATE: begin
                            n_state = S_FIN;
                            if (r_cnt >= CW'(rrts_pkg::MAX_THREADS)) begin
                                n_res.status = rrts_pkg::ST_FULL;
                            end else begin
                                mem_we            = 1'b1;
                                mem_waddr         = r_cnt[SW-1:0];
                                mem_wdata.id      = i_item.thr_id;
                                mem_wdata.state   = rrts_pkg::TS_CREATED;
                                mem_wdata.ip      = i_item.start_addr;
                                mem_wdata.start_a = i_item.start_addr;
                                mem_wdata.end_a   = i_item.end_addr;
                                mem_wdata.ticks   = '0;
                                n_cnt             = r_cnt + 5'd1;
                            end
                        end
                        rrts_pkg::K_SHUTDOWN: begin
                            n_state = S_FIN;
                            if (r_cnt > 5'd1) begin
                                n_cnt = 5'd1;
                            end
                            if (r_run != 5'd0) begin
                                n_run    = rrts_pkg::NO_SLOT;
                                n_run_id = '0;
                            end
                        end
                        rrts_pkg::K_TICK: begin
                            if (run_ok) begin
                                mem_re    = 1'b1;
                                mem_raddr = run_s;
                                n_state   = S_TICK;
                            end else begin
                                n_state = S_FIN;
                            end
                        end
                        default: begin
                            n_state = S_FIND;
                        end
                    endcase
                end
            end

            // pipelined id search, lowest slot wins
            S_FIND: begin
                if (issue) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_k[SW-1:0];
                    n_pslot   = r_k[SW-1:0];
                    n_k       = r_k + 5'd1;
                end
                n_pend = issue;
                if (r_pend && mem_rdata.id == r_tid) begin
                    n_slot  = r_pslot;
                    n_row   = mem_rdata;
                    n_state = S_DISP;
                end else if (!issue && !r_pend) begin
                    if (r_item.kind != rrts_pkg::K_TICK) begin
                        n_res.status = rrts_pkg::ST_NOTFOUND;
                    end
                    n_state = S_FIN;
                end
            end

            S_DISP: begin
                n_state = S_FIN;
                n_ptr   = first[SW-1:0];
                n_k     = '0;
                n_pend  = 1'b0;
                case (r_item.kind)
                    rrts_pkg::K_START: begin
                        if (is_run) begin
                            n_res.status = rrts_pkg::ST_ACTIVE_A;
                        end else begin
                            n_tslot = r_slot;
                            n_state = S_ACT_RD;
                        end
                    end
                    rrts_pkg::K_WAIT: begin
                        if (is_run) begin
                            n_state = S_NXT;
                        end else begin
                            mem_we          = 1'b1;
                            mem_wdata.state = rrts_pkg::TS_WAITING;
                        end
                    end
                    rrts_pkg::K_STOP, rrts_pkg::K_TICK: begin
                        if (is_run) begin
                            n_stopm = 1'b1;
                            n_state = S_NXT;
                        end else begin
                            mem_we          = 1'b1;
                            mem_wdata.state = rrts_pkg::TS_STOPPED;
                        end
                    end
                    rrts_pkg::K_DESTROY: begin
                        if (r_slot == '0) begin
                            n_res.status = rrts_pkg::ST_MAIN;
                        end else if (is_run) begin
                            n_res.status = rrts_pkg::ST_CURRENT;
                        end else if (r_row.state != rrts_pkg::TS_STOPPED) begin
                            n_res.status = rrts_pkg::ST_NOTSTOP;
                        end else begin
                            n_ptr   = r_slot;
                            n_state = S_CMP_RD;
                        end
                    end
                    rrts_pkg::K_QUERY: begin
                        case (r_item.query_field)
                            rrts_pkg::Q_ID:    n_res.query_value = {16'd0, r_row.id};
                            rrts_pkg::Q_STATE: n_res.query_value = {29'd0, r_row.state};
                            rrts_pkg::Q_TICKS: n_res.query_value = {15'd0, r_row.ticks};
                            rrts_pkg::Q_IP:    n_res.query_value = r_row.ip;
                            rrts_pkg::Q_START: n_res.query_value = r_row.start_a;
                            rrts_pkg::Q_END:   n_res.query_value = r_row.end_a;
                            default:           n_res.query_value = 32'hFFFF_FFFF;
                        endcase
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end

            // running thread's row is on the read port
            S_TICK: begin
                mem_waddr = run_s;
                mem_wdata = mem_rdata;
                n_ptr     = first[SW-1:0];
                if (r_item.cur_ip >= mem_rdata.end_a) begin
                    n_tid   = r_run_id;
                    n_state = S_FIND;
                end else if (mem_rdata.ticks > {1'b0, r_ts}) begin
                    mem_we          = 1'b1;
                    mem_wdata.ticks = '0;
                    n_state         = S_NXT;
                end else begin
                    mem_we          = 1'b1;
                    mem_wdata.ticks = mem_rdata.ticks + 17'd1;
                    n_state         = S_FIN;
                end
            end

            // destroy: shift rows above the slot down by one
            S_CMP_RD: begin
                if (ptr_nx < r_cnt) begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_nx[SW-1:0];
                    n_state   = S_CMP_WR;
                end else begin
                    if (run_ok && r_run > {1'b0, r_slot}) begin
                        n_run = r_run - 5'd1;
                    end
                    n_cnt   = r_cnt - 5'd1;
                    n_state = S_FIN;
                end
            end
            S_CMP_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                mem_wdata = mem_rdata;
                n_ptr     = ptr_nx[SW-1:0];
                n_state   = S_CMP_RD;
            end

            // round-robin scan for a waiting thread, one pass, skips runner
            S_NXT: begin
                n_pend = 1'b0;
                if (issue) begin
                    mem_re    = !(run_ok && {1'b0, r_ptr} == r_run);
                    mem_raddr = r_ptr;
                    n_pslot   = r_ptr;
                    n_pend    = mem_re;
                    n_ptr     = wrap_nx[SW-1:0];
                    n_k       = r_k + 5'd1;
                end
                if (r_pend && mem_rdata.state == rrts_pkg::TS_WAITING) begin
                    n_tslot = r_pslot;
                    n_row   = mem_rdata;
                    n_state = S_ACT_RD;
                end else if (!issue && !r_pend) begin
                    n_state = r_stopm ? S_STOP_RD : S_FIN;
                end
            end

            S_ACT_RD: begin
                if (run_ok) begin
                    mem_re    = 1'b1;
                    mem_raddr = run_s;
                    n_state   = S_ACT_WR1;
                end else begin
                    n_state = S_ACT_WR2;
                end
            end
            S_ACT_WR1: begin
                mem_we          = 1'b1;
                mem_waddr       = run_s;
                mem_wdata       = mem_rdata;
                mem_wdata.ip    = r_item.cur_ip;
                mem_wdata.state = rrts_pkg::TS_WAITING;
                n_state         = S_ACT_WR2;
            end
            S_ACT_WR2: begin
                mem_we            = 1'b1;
                mem_waddr         = r_tslot;
                mem_wdata.state   = rrts_pkg::TS_ACTIVE;
                n_run             = {1'b0, r_tslot};
                n_run_id          = r_row.id;
                n_res.switched    = 1'b1;
                n_res.new_ip      = r_row.ip;
                n_res.new_start   = r_row.start_a;
                n_res.new_end     = r_row.end_a;
                n_state           = r_stopm ? S_STOP_RD : S_FIN;
            end

            // re-read: the scan may have saved a new pointer in this row
            S_STOP_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_slot;
                n_state   = S_STOP_WR;
            end
            S_STOP_WR: begin
                mem_we          = 1'b1;
                mem_wdata       = mem_rdata;
                mem_wdata.state = rrts_pkg::TS_STOPPED;
                n_state         = S_FIN;
            end

            S_FIN: begin
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_run    <= rrts_pkg::NO_SLOT;
            r_cnt    <= '0;
            r_run_id <= '0;
            r_ts     <= rrts_pkg::TS_RESET;
            r_pend   <= 1'b0;
            r_stopm  <= 1'b0;
            r_k      <= '0;
        end else begin
            r_state  <= n_state;
            r_run    <= n_run;
            r_cnt    <= n_cnt;
            r_run_id <= n_run_id;
            r_pend   <= n_pend;
            r_stopm  <= n_stopm;
            r_k      <= n_k;
            if (i_cfg_we) begin
                r_ts <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_tid   <= n_tid;
        r_slot  <= n_slot;
        r_tslot <= n_tslot;
        r_ptr   <= n_ptr;
        r_pslot <= n_pslot;
        r_row   <= n_row;
        r_res   <= n_res;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_FIN);

    always_comb begin
        o_result              = r_res;
        o_result.current_slot = run_ok ? r_run : rrts_pkg::NO_SLOT;
        o_result.thread_count = r_cnt;
    end

endmodule

// ----- verif/round_robin_thread_scheduler_tb.sv -----
`timescale 1ns / 1ps

module round_robin_thread_scheduler_tb;

    localparam logic [2:0] TS_TERMINATED = 3'd4;
    localparam int N_RANDOM = 1500;
    localparam int DRAIN_CYCLES = 2 * rrts_pkg::MAX_THREADS + 40;

    // Scoreboard: carries its own copy of the thread table, predicts each
    // event's result word when the event is accepted, and checks result words
    // in order.
    class sched_board;
        logic [15:0]                 tid_tab   [rrts_pkg::MAX_THREADS];
        logic [2:0]                  state_tab [rrts_pkg::MAX_THREADS];
        logic [31:0]                 ip_tab    [rrts_pkg::MAX_THREADS];
        logic [31:0]                 start_tab [rrts_pkg::MAX_THREADS];
        logic [31:0]                 end_tab   [rrts_pkg::MAX_THREADS];
        logic [rrts_pkg::TICK_W-1:0] tick_tab  [rrts_pkg::MAX_THREADS];
        logic [4:0]        run_slot;
        logic [4:0]        n_thr;
        logic [15:0]       run_tid;
        logic [15:0]       slice;
        rrts_pkg::t_result want_q[$];
        int                errors;
        int                n_checked;
        int                n_switches;

        function new();
            run_slot = rrts_pkg::NO_SLOT;
            n_thr = 0;
            run_tid = 0;
            slice = rrts_pkg::TS_RESET;
            errors = 0;
            n_checked = 0;
            n_switches = 0;
        endfunction

        function bit running();
            return run_slot < n_thr;
        endfunction

        function bit lookup(logic [15:0] id, output int slot);
            for (int i = 0; i < n_thr; i++) begin
                if (tid_tab[i] == id) begin
                    slot = i;
                    return 1;
                end
            end
            slot = 0;
            return 0;
        endfunction

        function void switch_to(int slot, logic [31:0] ip, ref rrts_pkg::t_result r);
            if (running()) begin
                ip_tab[run_slot] = ip;
                state_tab[run_slot] = rrts_pkg::TS_WAITING;
            end
            run_slot = 5'(slot);
            state_tab[slot] = rrts_pkg::TS_ACTIVE;
            run_tid = tid_tab[slot];
            r.switched = 1'b1;
            r.new_ip = ip_tab[slot];
            r.new_start = start_tab[slot];
            r.new_end = end_tab[slot];
        endfunction

        // one round-robin pass from the slot after the running one
        function void rr_scan(logic [31:0] ip, ref rrts_pkg::t_result r);
            int n;
            int base;
            int s;
            n = n_thr;
            if (n == 0) return;
            base = running() ? int'(run_slot) : n - 1;
            for (int k = 1; k <= n; k++) begin
                s = (base + k) % n;
                if (running() && s == run_slot) continue;
                if (state_tab[s] == rrts_pkg::TS_WAITING) begin
                    switch_to(s, ip, r);
                    return;
                end
            end
        endfunction

        function void halt(int slot, logic [31:0] ip, ref rrts_pkg::t_result r);
            if (running() && slot == run_slot) rr_scan(ip, r);
            state_tab[slot] = rrts_pkg::TS_STOPPED;
        endfunction

        function void note_event(rrts_pkg::t_item it);
            rrts_pkg::t_result r;
            int slot;
            bit hit;
            r = '0;
            case (it.kind)
                rrts_pkg::K_CREATE: begin
                    if (n_thr >= rrts_pkg::MAX_THREADS) begin
                        r.status = rrts_pkg::ST_FULL;
                    end else begin
                        tid_tab[n_thr] = it.thr_id;
                        start_tab[n_thr] = it.start_addr;
                        end_tab[n_thr] = it.end_addr;
                        ip_tab[n_thr] = it.start_addr;
                        state_tab[n_thr] = rrts_pkg::TS_CREATED;
                        tick_tab[n_thr] = 0;
                        n_thr++;
                    end
                end
                rrts_pkg::K_START: begin
                    if (!lookup(it.thr_id, slot)) r.status = rrts_pkg::ST_NOTFOUND;
                    else if (running() && slot == run_slot) r.status = rrts_pkg::ST_ACTIVE_A;
                    else switch_to(slot, it.cur_ip, r);
                end
                rrts_pkg::K_WAIT: begin
                    if (!lookup(it.thr_id, slot)) r.status = rrts_pkg::ST_NOTFOUND;
                    else if (running() && slot == run_slot) rr_scan(it.cur_ip, r);
                    else state_tab[slot] = rrts_pkg::TS_WAITING;
                end
                rrts_pkg::K_STOP: begin
                    if (!lookup(it.thr_id, slot)) r.status = rrts_pkg::ST_NOTFOUND;
                    else halt(slot, it.cur_ip, r);
                end
                rrts_pkg::K_DESTROY: begin
                    if (!lookup(it.thr_id, slot)) r.status = rrts_pkg::ST_NOTFOUND;
                    else if (slot == 0) r.status = rrts_pkg::ST_MAIN;
                    else if (running() && slot == run_slot) r.status = rrts_pkg::ST_CURRENT;
                    else if (state_tab[slot] != rrts_pkg::TS_STOPPED)
                        r.status = rrts_pkg::ST_NOTSTOP;
                    else begin
                        for (int i = slot; i + 1 < n_thr; i++) begin
                            tid_tab[i] = tid_tab[i+1];
                            state_tab[i] = state_tab[i+1];
                            ip_tab[i] = ip_tab[i+1];
                            start_tab[i] = start_tab[i+1];
                            end_tab[i] = end_tab[i+1];
                            tick_tab[i] = tick_tab[i+1];
                        end
                        if (running() && run_slot > slot) run_slot--;
                        n_thr--;
                    end
                end
                rrts_pkg::K_TICK: begin
                    if (running()) begin
                        if (it.cur_ip >= end_tab[run_slot]) begin
                            // end reached: stop by id, lowest slot wins
                            hit = lookup(run_tid, slot);
                            if (hit) halt(slot, it.cur_ip, r);
                        end else if (tick_tab[run_slot] > {1'b0, slice}) begin
                            tick_tab[run_slot] = 0;
                            rr_scan(it.cur_ip, r);
                        end else begin
                            tick_tab[run_slot] = tick_tab[run_slot] + 1'b1;
                        end
                    end
                end
                rrts_pkg::K_QUERY: begin
                    if (!lookup(it.thr_id, slot)) begin
                        r.status = rrts_pkg::ST_NOTFOUND;
                    end else begin
                        case (it.query_field)
                            rrts_pkg::Q_ID:    r.query_value = {16'd0, tid_tab[slot]};
                            rrts_pkg::Q_STATE: r.query_value = {29'd0, state_tab[slot]};
                            rrts_pkg::Q_TICKS: r.query_value = {15'd0, tick_tab[slot]};
                            rrts_pkg::Q_IP:    r.query_value = ip_tab[slot];
                            rrts_pkg::Q_START: r.query_value = start_tab[slot];
                            rrts_pkg::Q_END:   r.query_value = end_tab[slot];
                            default:           r.query_value = 32'hFFFF_FFFF;
                        endcase
                    end
                end
                default: begin
                    // shutdown keeps slot 0 only
                    for (int i = 1; i < n_thr; i++) begin
                        tid_tab[i] = 0;
                        state_tab[i] = TS_TERMINATED;
                        ip_tab[i] = 0;
                        start_tab[i] = 0;
                        end_tab[i] = 0;
                        tick_tab[i] = 0;
                    end
                    if (n_thr > 1) n_thr = 1;
                    if (run_slot != 0) begin
                        run_slot = rrts_pkg::NO_SLOT;
                        run_tid = 0;
                    end
                end
            endcase
            r.current_slot = running() ? run_slot : rrts_pkg::NO_SLOT;
            r.thread_count = n_thr;
            if (r.switched) n_switches++;
            want_q.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        endtask

        task check_word(rrts_pkg::t_result got);
            rrts_pkg::t_result w;
            if (want_q.size() == 0) begin
                report("unexpected result word", 32'(got.status), 32'd0);
                return;
            end
            w = want_q.pop_front();
            n_checked++;
            if (got.status !== w.status)
                report("status", 32'(got.status), 32'(w.status));
            if (got.switched !== w.switched)
                report("switched", 32'(got.switched), 32'(w.switched));
            if (got.new_ip !== w.new_ip) report("new_ip", got.new_ip, w.new_ip);
            if (got.new_start !== w.new_start) report("new_start", got.new_start, w.new_start);
            if (got.new_end !== w.new_end) report("new_end", got.new_end, w.new_end);
            if (got.current_slot !== w.current_slot)
                report("current_slot", 32'(got.current_slot), 32'(w.current_slot));
            if (got.thread_count !== w.thread_count)
                report("thread_count", 32'(got.thread_count), 32'(w.thread_count));
            if (got.query_value !== w.query_value)
                report("query_value", got.query_value, w.query_value);
        endtask

        function int pending();
            return want_q.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    rrts_pkg::t_item   i_item;
    logic              o_done;
    rrts_pkg::t_result o_result;
    logic              i_cfg_we;
    logic [15:0]       i_cfg_data;

    sched_board board;
    int         n_sent;
    int         n_slices;

    round_robin_thread_scheduler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Sample at the rising edge: an event is taken when start && !busy, and
    // every o_done strobe carries exactly one result word.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) board.check_word(o_result);
            if (start && !busy) board.note_event(i_item);
        end
    end

    // Overall limit: 1500 random events plus the directed ones and gaps, taken
    // many times over.
    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic rrts_pkg::t_item mk(logic [2:0] kind, logic [15:0] id,
                                           logic [31:0] sa, logic [31:0] ea,
                                           logic [31:0] ip, logic [2:0] qf);
        rrts_pkg::t_item it;
        it.kind = kind;
        it.thr_id = id;
        it.start_addr = sa;
        it.end_addr = ea;
        it.cur_ip = ip;
        it.query_field = qf;
        return it;
    endfunction

    // Present one event at the falling edge; hold it until it is taken.
    task send(rrts_pkg::t_item it);
        @(negedge i_clk);
        start <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        n_sent++;
    endtask

    task pause(int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        i_item <= '0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task drain();
        pause(0);
        while (board.pending() > 0) @(posedge i_clk);
    endtask

    // Time slice is only written with the block idle.
    task set_slice(logic [15:0] v);
        drain();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        i_cfg_data <= 16'($urandom);
        board.slice = v;
        n_slices++;
    endtask

    // Random event, biased toward a small id pool so lookups hit and
    // well-formed create/start/wait/stop/destroy sequences build up.
    function automatic rrts_pkg::t_item rand_event();
        rrts_pkg::t_item it;
        int    pick;
        logic [2:0] k;
        pick = $urandom_range(0, 99);
        if (pick < 12) k = rrts_pkg::K_CREATE;
        else if (pick < 24) k = rrts_pkg::K_START;
        else if (pick < 34) k = rrts_pkg::K_WAIT;
        else if (pick < 44) k = rrts_pkg::K_STOP;
        else if (pick < 54) k = rrts_pkg::K_DESTROY;
        else if (pick < 84) k = rrts_pkg::K_TICK;
        else if (pick < 98) k = rrts_pkg::K_QUERY;
        else k = rrts_pkg::K_SHUTDOWN;
        it.kind = k;
        it.thr_id = ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, 6));
        it.start_addr = $urandom;
        // end addresses mostly high so ticks usually run the slice out
        it.end_addr = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom | 32'h8000_0000);
        case ($urandom_range(0, 9))
            0: it.cur_ip = 32'hFFFF_FFFF;
            1: it.cur_ip = 32'd0;
            2, 3: it.cur_ip = $urandom;
            default: it.cur_ip = $urandom & 32'h7FFF_FFFF;
        endcase
        it.query_field = 3'($urandom_range(0, 7));
        return it;
    endfunction

    initial begin
        int burst;
        board = new();
        n_sent = 0;
        n_slices = 0;
        start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, main thread, duplicates, refusals, full table
        send(mk(rrts_pkg::K_TICK, 16'd0, 0, 0, 32'h10, rrts_pkg::Q_ID));
        send(mk(rrts_pkg::K_START, 16'hFFFF, 0, 0, 0, rrts_pkg::Q_ID));
        send(mk(rrts_pkg::K_CREATE, 16'd0, 32'h100, 32'h200, 0, rrts_pkg::Q_ID));
        send(mk(rrts_pkg::K_CREATE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0,
                rrts_pkg::Q_ID));
        send(mk(rrts_pkg::K_CREATE, 16'hFFFF, 32'h0, 32'h0, 0, rrts_pkg::Q_ID));
        for (int q = 0; q < 8; q++)
            send(mk(rrts_pkg::K_QUERY, 16'hFFFF, 0, 0, 0, 3'(q)));
        send(mk(rrts_pkg::K_START, 16'hFFFF, 0, 0, 32'h55, rrts_pkg::Q_ID));
        send(mk(rrts_pkg::K_START, 16'hFFFF, 0, 0, 32'h66, rrts_pkg::Q_ID));
        send(mk(rrts_pkg::K_START, 16'd0, 0, 0, 32'h1234, rrts_pkg::Q_ID));
        send(mk(rrts_pkg::K_WAIT, 16'd0, 0, 0, 32'h150, rrts_pkg::Q_ID));
        send(mk(rrts_pkg::K_STOP, 16'hFFFF, 0, 0, 32'h77, rrts_pkg::Q_ID));
        send(mk(rrts_pkg::K_DESTROY, 16'd0, 0, 0, 0, rrts_pkg::Q_ID));
        send(mk(rrts_pkg::K_DESTROY, 16'hFFFF, 0, 0, 0, rrts_pkg::Q_ID));
        send(mk(rrts_pkg::K_DESTROY, 16'h1234, 0, 0, 0, rrts_pkg::Q_ID));
        send(mk(rrts_pkg::K_TICK, 16'd0, 0, 0, 32'hFFFF_FFFF, rrts_pkg::Q_ID));
        for (int i = 0; i < 15; i++)
            send(mk(rrts_pkg::K_CREATE, 16'(i + 2), 32'(i), 32'hFFFF_0000, 0,
                    rrts_pkg::Q_ID));
        send(mk(rrts_pkg::K_SHUTDOWN, 16'd0, 0, 0, 0, rrts_pkg::Q_ID));
        send(mk(rrts_pkg::K_QUERY, 16'd0, 0, 0, 0, rrts_pkg::Q_STATE));

        // random phases across several slice settings, extremes included
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_slice(16'd0);
                1: set_slice(16'd3);
                2: set_slice(16'hFFFF);
                3: set_slice(16'($urandom_range(1, 12)));
                default: set_slice(rrts_pkg::TS_RESET);
            endcase
            for (int n = 0; n < N_RANDOM / 5; ) begin
                burst = $urandom_range(1, 24);
                for (int b = 0; b < burst && n < N_RANDOM / 5; b++, n++)
                    send(rand_event());
                case ($urandom_range(0, 9))
                    0: drain();
                    1, 2, 3: ;
                    default: pause($urandom_range(0, 8));
                endcase
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d events, %0d result words, %0d thread switches,",
                 n_sent, board.n_checked, board.n_switches);
        $display("over %0d time slice settings from 0 to 65535.", n_slices + 1);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
